>>> rtl/dq_pkg.sv
// Shared types and constants for the double-ended queue.
package dq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned ENTRY_BYTES = 8;

  localparam int unsigned ENTRY_W = 8 * ENTRY_BYTES;
  localparam int unsigned PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned COUNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W   = PTR_W + 5;

  // Fixed port widths
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_HEAD = 3'd0,
    CMD_PUSH_TAIL = 3'd1,
    CMD_POP_HEAD  = 3'd2,
    CMD_POP_TAIL  = 3'd3,
    CMD_PEEK_HEAD = 3'd4,
    CMD_PEEK_TAIL = 3'd5,
    CMD_READ_IDX  = 3'd6,
    CMD_CLEAR     = 3'd7
  } dq_cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_RANGE = 2'd2,
    STS_FULL  = 2'd3
  } dq_status_e;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } dq_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the input beat and launch the store read
    logic commit;   // apply the command and load the result register
  } dq_ctl_t;

endpackage

>>> rtl/dq_ctrl.sv
// Controller state machine: sequences capture and commit, owns the output valid.
module dq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output dq_pkg::dq_ctl_t ctl_o
);

  dq_pkg::dq_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dq_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    ctl_o.capture = 1'b0;
    ctl_o.commit  = 1'b0;
    case (state_q)
      dq_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        ctl_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = dq_pkg::ST_EXEC;
        end
      end
      dq_pkg::ST_EXEC: begin
        // wait while the result register still holds an untaken beat
        if (!out_valid_q || out_ready_i) begin
          ctl_o.commit = 1'b1;
          state_d      = dq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dq_pkg::ST_IDLE;
      end
    endcase

    if (ctl_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/dq_datapath.sv
// Datapath: entry store, ring pointers, count and result register.
module dq_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dq_pkg::dq_ctl_t               ctl_i,
  input  logic [dq_pkg::CMD_W-1:0]      command_i,
  input  logic [dq_pkg::DATA_W-1:0]     entry_data_i,
  input  logic [dq_pkg::POS_W-1:0]      position_i,
  output logic [dq_pkg::STATUS_W-1:0]   status_o,
  output logic [dq_pkg::DATA_W-1:0]     read_data_o,
  output logic [dq_pkg::OCC_W-1:0]      occupancy_o
);

  localparam logic [dq_pkg::PTR_W-1:0] LastSlot = dq_pkg::PTR_W'(dq_pkg::QUEUE_DEPTH - 1);
  localparam logic [dq_pkg::COUNT_W-1:0] FullCount = dq_pkg::COUNT_W'(dq_pkg::QUEUE_DEPTH);
  localparam logic [dq_pkg::SUM_W-1:0] DepthSum = dq_pkg::SUM_W'(dq_pkg::QUEUE_DEPTH);

  logic [dq_pkg::ENTRY_W-1:0] mem_q [dq_pkg::QUEUE_DEPTH];

  logic [dq_pkg::PTR_W-1:0]   head_q, head_d, tail_q, tail_d;
  logic [dq_pkg::COUNT_W-1:0] count_q, count_d;

  // captured beat
  dq_pkg::dq_cmd_e            cmd_q;
  logic [dq_pkg::ENTRY_W-1:0] wdata_q;
  logic [dq_pkg::POS_W-1:0]   pos_q;
  logic [dq_pkg::ENTRY_W-1:0] rdata_q;

  logic [dq_pkg::STATUS_W-1:0] status_q, status_d;
  logic [dq_pkg::ENTRY_W-1:0]  rd_q, rd_d;
  logic [dq_pkg::COUNT_W-1:0]  occ_q;

  logic [dq_pkg::PTR_W-1:0] rd_addr, wr_addr;
  logic [dq_pkg::SUM_W-1:0] idx_sum;
  logic                     wr_en;
  logic [dq_pkg::PTR_W-1:0] head_next, tail_next, head_prev, tail_prev;
  logic                     empty, full;

  // ring neighbors
  always_comb begin
    head_next = (head_q == LastSlot) ? '0 : head_q + 1'b1;
    tail_next = (tail_q == LastSlot) ? '0 : tail_q + 1'b1;
    head_prev = (head_q == '0) ? LastSlot : head_q - 1'b1;
    tail_prev = (tail_q == '0) ? LastSlot : tail_q - 1'b1;
  end

  // read address from the incoming beat
  always_comb begin
    idx_sum = dq_pkg::SUM_W'(tail_q) + dq_pkg::SUM_W'(position_i);
    if (idx_sum >= DepthSum) begin
      idx_sum = idx_sum - DepthSum;
    end
    case (command_i)
      dq_pkg::CMD_POP_HEAD, dq_pkg::CMD_PEEK_HEAD: rd_addr = head_q;
      dq_pkg::CMD_POP_TAIL, dq_pkg::CMD_PEEK_TAIL: rd_addr = tail_q;
      dq_pkg::CMD_READ_IDX:                        rd_addr = idx_sum[dq_pkg::PTR_W-1:0];
      default:                                     rd_addr = head_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q   <= dq_pkg::dq_cmd_e'(command_i);
      wdata_q <= entry_data_i[dq_pkg::ENTRY_W-1:0];
      pos_q   <= position_i;
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wdata_q;
    end
  end

  assign empty = (count_q == '0);
  assign full  = (count_q == FullCount);

  // command execution
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    status_d = dq_pkg::STS_OK;
    rd_d     = '0;
    wr_en    = 1'b0;
    wr_addr  = head_q;
    case (cmd_q)
      dq_pkg::CMD_PUSH_HEAD, dq_pkg::CMD_PUSH_TAIL: begin
        if (full) begin
          status_d = dq_pkg::STS_FULL;
        end else if (empty) begin
          tail_d  = head_q;
          wr_en   = ctl_i.commit;
          wr_addr = head_q;
          count_d = dq_pkg::COUNT_W'(1);
        end else if (cmd_q == dq_pkg::CMD_PUSH_HEAD) begin
          head_d  = head_next;
          wr_en   = ctl_i.commit;
          wr_addr = head_next;
          count_d = count_q + 1'b1;
        end else begin
          tail_d  = tail_prev;
          wr_en   = ctl_i.commit;
          wr_addr = tail_prev;
          count_d = count_q + 1'b1;
        end
      end
      dq_pkg::CMD_POP_HEAD, dq_pkg::CMD_POP_TAIL,
      dq_pkg::CMD_PEEK_HEAD, dq_pkg::CMD_PEEK_TAIL: begin
        if (empty) begin
          status_d = dq_pkg::STS_EMPTY;
        end else begin
          rd_d = rdata_q;
          if (cmd_q == dq_pkg::CMD_POP_HEAD || cmd_q == dq_pkg::CMD_POP_TAIL) begin
            count_d = count_q - 1'b1;
            // last entry leaves the pointers where they are
            if (count_q != dq_pkg::COUNT_W'(1)) begin
              if (cmd_q == dq_pkg::CMD_POP_HEAD) begin
                head_d = head_prev;
              end else begin
                tail_d = tail_next;
              end
            end
          end
        end
      end
      dq_pkg::CMD_READ_IDX: begin
        if (dq_pkg::SUM_W'(pos_q) >= dq_pkg::SUM_W'(count_q)) begin
          status_d = dq_pkg::STS_RANGE;
        end else begin
          rd_d = rdata_q;
        end
      end
      dq_pkg::CMD_CLEAR: begin
        head_d  = '0;
        tail_d  = '0;
        count_d = '0;
      end
      default: begin
        status_d = dq_pkg::STS_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (ctl_i.commit) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.commit) begin
      status_q <= status_d;
      rd_q     <= rd_d;
      occ_q    <= count_d;
    end
  end

  assign status_o    = status_q;
  assign read_data_o = dq_pkg::DATA_W'(rd_q);
  assign occupancy_o = dq_pkg::OCC_W'(occ_q);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCount)
    else $error("count beyond depth");

  a_single_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == dq_pkg::COUNT_W'(1) |-> head_q == tail_q)
    else $error("single entry but head and tail differ");

  a_full_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.commit && full &&
    (cmd_q == dq_pkg::CMD_PUSH_HEAD || cmd_q == dq_pkg::CMD_PUSH_TAIL)
    |=> $stable(count_q) && $stable(head_q) && $stable(tail_q))
    else $error("rejected push changed state");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.commit && cmd_q == dq_pkg::CMD_CLEAR
    |=> count_q == '0 && head_q == '0 && tail_q == '0)
    else $error("clear left state behind");
`endif

endmodule

>>> rtl/double_ended_queue_core.sv
// Top level of the double-ended queue: controller plus datapath.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one command beat:
//   command_i, entry_data_i (value for pushes) and position_i (index from
//   the tail for an indexed read). Output channel (out_valid_o /
//   out_ready_i) returns exactly one result beat per command: status_o,
//   read_data_o (zero unless a pop, peek or indexed read succeeds) and
//   occupancy_o (entries held after the command).
// Sequencing:
//   A command is accepted in the idle state and its store read lands in a
//   register. The EXEC state then commits it and raises out_valid_o,
//   unless an earlier result beat is still untaken. A new command is not
//   taken until the last one commits: capture in IDLE, commit in EXEC.
// Reset:
//   rst_ni clears head, tail and count to zero and drops out_valid_o.
//   Store contents are not cleared; only live slots are ever returned.
// Back-pressure:
//   The next command is still accepted while a result waits; its commit is
//   held until the waiting result beat is taken.
module double_ended_queue_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dq_pkg::CMD_W-1:0]    command_i,
  input  logic [dq_pkg::DATA_W-1:0]   entry_data_i,
  input  logic [dq_pkg::POS_W-1:0]    position_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [dq_pkg::STATUS_W-1:0] status_o,
  output logic [dq_pkg::DATA_W-1:0]   read_data_o,
  output logic [dq_pkg::OCC_W-1:0]    occupancy_o
);

  dq_pkg::dq_ctl_t ctl;

  // sequencing and output handshake
  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctl_o       (ctl)
  );

  // store, pointers and result register
  dq_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .command_i    (command_i),
    .entry_data_i (entry_data_i),
    .position_i   (position_i),
    .status_o     (status_o),
    .read_data_o  (read_data_o),
    .occupancy_o  (occupancy_o)
  );

endmodule
